FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the runtime table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pwlrt_pkg.sv
// ----------------------------------------------------------------------------
// pwlrt_pkg
// Types and fixed constants for the piecewise-linear runtime table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlrt_pkg;

    localparam int MACHINE_W = 3;
    localparam int KEY_W     = 32;
    localparam int RT_W      = 32;
    localparam int FRAC_W    = 17;
    localparam int STATUS_W  = 2;

    // Completed fraction of one, Q1.16.
    localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                 cmd;
        logic [MACHINE_W-1:0] machine;
        logic [KEY_W-1:0]     units;
        logic [RT_W-1:0]      new_runtime;
        logic [FRAC_W-1:0]    completed;
    } req_t;

    typedef struct packed {
        logic [RT_W-1:0]     runtime_left;
        logic                exact_hit;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // One stored breakpoint.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [RT_W-1:0]  runtime;
    } point_t;

    // Operands handed to the arithmetic unit for one query.
    typedef struct packed {
        logic              exact;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  k0;
        logic [KEY_W-1:0]  k1;
        logic [RT_W-1:0]   r0;
        logic [RT_W-1:0]   r1;
        logic [FRAC_W-1:0] completed;
    } arith_req_t;

endpackage

`default_nettype wire

FILE: hdl/pwlrt_arith.sv
// ----------------------------------------------------------------------------
// pwlrt_arith
// Shared multiplier and restoring divider that interpolate and scale a runtime.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlrt_arith
    import pwlrt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire arith_req_t      req,
    output logic                 done,
    output logic [RT_W-1:0]      result
);

    localparam int STEP_W = $clog2(RT_W);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL0 = 3'd1;
    localparam logic [2:0] A_MUL1 = 3'd2;
    localparam logic [2:0] A_SUM  = 3'd3;
    localparam logic [2:0] A_DIV  = 3'd4;
    localparam logic [2:0] A_RND  = 3'd5;
    localparam logic [2:0] A_SC0  = 3'd6;
    localparam logic [2:0] A_SC1  = 3'd7;

    logic [2:0]            state_reg, state_next;
    arith_req_t            req_reg;
    logic [2*RT_W-1:0]     mul_reg;
    logic [2*RT_W-1:0]     acc_reg;
    logic [RT_W-1:0]       rem_reg, quo_reg, rt_reg, result_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  done_reg;

    logic [RT_W-1:0]       mul_a, mul_b;
    logic [KEY_W-1:0]      span;
    logic [RT_W:0]         trial;
    logic                  fits;
    logic                  round_up;
    logic [FRAC_W-1:0]     factor;
    logic [2*RT_W-1:0]     num;
    logic [47:0]           scaled;

    // Breakpoint spacing is the divisor; it is never zero for distinct keys.
    assign span     = req_reg.k1 - req_reg.k0;
    assign trial    = {rem_reg, quo_reg[RT_W-1]};
    assign fits     = trial >= {1'b0, span};
    assign round_up = {rem_reg, 1'b0} >= {1'b0, span};
    assign factor   = (req_reg.completed > ONE_Q16) ? '0 : ONE_Q16 - req_reg.completed;
    assign num      = acc_reg + mul_reg;
    assign scaled   = mul_reg[47:0] + 48'd32768;

    always_comb
    begin
        mul_a = req_reg.r0;
        mul_b = req_reg.k1 - req_reg.key;
        case (state_reg)
            A_MUL1:
            begin
                mul_a = req_reg.r1;
                mul_b = req_reg.key - req_reg.k0;
            end
            A_SC0:
            begin
                mul_a = rt_reg;
                mul_b = RT_W'(factor);
            end
            default:
            begin
                mul_a = req_reg.r0;
                mul_b = req_reg.k1 - req_reg.key;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: if (start) state_next = req.exact ? A_SC0 : A_MUL0;
            A_MUL0: state_next = A_MUL1;
            A_MUL1: state_next = A_SUM;
            A_SUM:  state_next = A_DIV;
            A_DIV:  if (step_reg == STEP_W'(RT_W - 1)) state_next = A_RND;
            A_RND:  state_next = A_SC0;
            A_SC0:  state_next = A_SC1;
            A_SC1:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == A_SC1);
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= (2*RT_W)'(mul_a) * (2*RT_W)'(mul_b);
        if (state_reg == A_IDLE && start)
        begin
            req_reg <= req;
            rt_reg  <= req.r1;
        end
        if (state_reg == A_MUL1)
        begin
            acc_reg <= mul_reg;
        end
        if (state_reg == A_SUM)
        begin
            // The weighted sum is below span * 2^32, so the high half starts
            // as a valid partial remainder.
            rem_reg  <= num[2*RT_W-1:RT_W];
            quo_reg  <= num[RT_W-1:0];
            step_reg <= '0;
        end
        if (state_reg == A_DIV)
        begin
            rem_reg  <= fits ? RT_W'(trial - {1'b0, span}) : trial[RT_W-1:0];
            quo_reg  <= {quo_reg[RT_W-2:0], fits};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (state_reg == A_RND)
        begin
            rt_reg <= quo_reg + RT_W'(round_up);
        end
        if (state_reg == A_SC1)
        begin
            result_reg <= scaled[47:16];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hdl/piecewise_linear_runtime_table_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_runtime_table_unit
// Per-machine sorted breakpoint tables with insert, exact lookup and
// linear interpolation of remaining runtime.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                      | Moves
//   --------+------------------------------+---------------------------------
//   req     | req_valid, req_stall, req_data | one load or query command
//   rsp     | rsp_valid, rsp_stall, rsp_data | one result per command
//
// The block works on one command at a time; req_stall is high from the
// transfer of a command until its result has been placed in the output
// register. A search examines up to n breakpoints at one per cycle, set by
// the single read port of the breakpoint memory. A load that lands inside
// the table first moves each breakpoint at or above its slot up by one,
// with a read and then a write. An interpolating query goes through the
// 32-step shared divider in the arithmetic unit; an exact-hit query skips it.
// Reset clears the per-machine counts but not the breakpoint memory, which
// needs no clearing pass, since only slots below a machine's count are used.
// A stalled result waits in the output register while the next command is
// taken; a second result then waits in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_runtime_table_unit
    import pwlrt_pkg::*;
#(
    parameter int MACHINES = 8,
    parameter int POINTS   = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,

    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    // Only machine indexes the field can carry get a table.
    localparam int MACHINE_SPAN = 2 ** MACHINE_W;
    localparam int TABLES       = (MACHINES < MACHINE_SPAN) ? MACHINES : MACHINE_SPAN;
    localparam int MIDX_W       = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int MEM_DEPTH    = TABLES * POINTS;
    localparam int AW           = $clog2(MEM_DEPTH);
    localparam int CNT_W        = $clog2(POINTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SH_RD  = 3'd2;
    localparam logic [2:0] S_SH_WR  = 3'd3;
    localparam logic [2:0] S_INS    = 3'd4;
    localparam logic [2:0] S_ARITH  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    function automatic logic [AW-1:0] slot_addr(input logic [MIDX_W-1:0] m,
                                                input logic [CNT_W-1:0] i);
        slot_addr = AW'(int'(m) * POINTS + int'(i));
    endfunction

    // Sequencer state and the command being worked on.
    logic [2:0]        state_reg, state_next;
    req_t              item_reg, item_next;
    logic [MIDX_W-1:0] midx_reg, midx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    point_t            prev_reg, prev_next;
    rsp_t              res_reg, res_next;

    logic [CNT_W-1:0]  point_count_reg [TABLES];
    logic              count_we;

    // Breakpoint memory: one write port, one registered read port.
    point_t            point_mem [MEM_DEPTH];
    point_t            mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    point_t            mem_wdata;

    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg;
    logic              push;

    logic              arith_start, arith_done, arith_exact;
    arith_req_t        arith_req;
    logic [RT_W-1:0]   arith_result;

    logic              mach_ok;
    logic [MIDX_W-1:0] req_midx;
    logic [CNT_W-1:0]  req_count;
    logic              key_ge, key_eq, at_last;
    logic [CNT_W-1:0]  found_pos;

    assign mach_ok   = int'(req_data.machine) < MACHINES;
    assign req_midx  = req_data.machine[MIDX_W-1:0];
    assign req_count = mach_ok ? point_count_reg[req_midx] : '0;

    // Search compares the breakpoint read in the previous cycle.
    assign key_ge  = mem_rdata_reg.key >= item_reg.units;
    assign key_eq  = mem_rdata_reg.key == item_reg.units;
    assign at_last = (idx_reg + CNT_W'(1)) == cnt_reg;
    assign found_pos = key_ge ? idx_reg : cnt_reg;

    assign arith_req = '{
        exact:     arith_exact,
        key:       item_reg.units,
        k0:        prev_reg.key,
        k1:        mem_rdata_reg.key,
        r0:        prev_reg.runtime,
        r1:        mem_rdata_reg.runtime,
        completed: item_reg.completed
    };

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        midx_next   = midx_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        res_next    = res_reg;
        push        = 1'b0;
        count_we    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = slot_addr(midx_reg, pos_reg);
        mem_wdata   = '{key: item_reg.units, runtime: item_reg.new_runtime};
        mem_raddr   = slot_addr(midx_reg, idx_reg + CNT_W'(1));
        arith_start = 1'b0;
        arith_exact = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = slot_addr(req_midx, '0);
                if (req_valid)
                begin
                    item_next = req_data;
                    midx_next = req_midx;
                    cnt_next  = req_count;
                    idx_next  = '0;
                    pos_next  = '0;
                    res_next  = '{runtime_left: '0, exact_hit: 1'b0, status: ST_OK};
                    if (!mach_ok)
                    begin
                        res_next.status = ST_NO_TABLE;
                        state_next      = S_FIN;
                    end
                    else if (req_count == '0)
                    begin
                        // An empty table takes a load straight into slot zero.
                        if (req_data.cmd == CMD_QUERY)
                        begin
                            res_next.status = ST_NO_TABLE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (key_ge || at_last)
                begin
                    pos_next = found_pos;
                    if (item_reg.cmd == CMD_LOAD)
                    begin
                        if (key_ge && key_eq)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_addr(midx_reg, found_pos);
                            state_next = S_FIN;
                        end
                        else if (cnt_reg == CNT_W'(POINTS))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else if (found_pos == cnt_reg)
                        begin
                            state_next = S_INS;
                        end
                        else
                        begin
                            idx_next   = cnt_reg;
                            state_next = S_SH_RD;
                        end
                    end
                    else
                    begin
                        if (key_ge && key_eq)
                        begin
                            arith_exact        = 1'b1;
                            arith_start        = 1'b1;
                            res_next.exact_hit = 1'b1;
                            state_next         = S_ARITH;
                        end
                        else if (found_pos == '0 || found_pos == cnt_reg)
                        begin
                            res_next.status = ST_RANGE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            arith_start = 1'b1;
                            state_next  = S_ARITH;
                        end
                    end
                end
                else
                begin
                    prev_next = mem_rdata_reg;
                    idx_next  = idx_reg + CNT_W'(1);
                end
            end

            S_SH_RD:
            begin
                mem_raddr  = slot_addr(midx_reg, idx_reg - CNT_W'(1));
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_addr(midx_reg, idx_reg);
                mem_wdata = mem_rdata_reg;
                idx_next  = idx_reg - CNT_W'(1);
                state_next = ((idx_reg - CNT_W'(1)) == pos_reg) ? S_INS : S_SH_RD;
            end

            S_INS:
            begin
                mem_we     = 1'b1;
                count_we   = 1'b1;
                state_next = S_FIN;
            end

            S_ARITH:
            begin
                if (arith_done)
                begin
                    res_next.runtime_left = arith_result;
                    state_next            = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < TABLES; i++)
            begin
                point_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (count_we)
            begin
                point_count_reg[midx_reg] <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        midx_reg <= midx_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        prev_reg <= prev_next;
        res_reg  <= res_next;
        if (push)
        begin
            rsp_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            point_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= point_mem[mem_raddr];
    end

    pwlrt_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (arith_start),
        .req    (arith_req),
        .done   (arith_done),
        .result (arith_result)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

FILE: hdl/pwlrt_checker.sv
// ----------------------------------------------------------------------------
// pwlrt_checker
// Port-level assertions for the piecewise-linear runtime table unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pwlrt_checker
    import pwlrt_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req_data,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp_data
);

    logic req_xfer;

    assign req_xfer = req_valid && !req_stall;

    // The unit works on one command at a time.
    `PWL_ASSERT_NXT(a_one_cmd_at_a_time, clk, rst_n, req_xfer, req_stall, "command taken while busy")

    // Failed commands report no runtime and no hit.
    `PWL_ASSERT_IMP(a_error_clears_payload, clk, rst_n, rsp_valid && (rsp_data.status != ST_OK), (rsp_data.runtime_left == '0) && !rsp_data.exact_hit, "error result carries payload")

    // An exact hit only comes with a good status.
    `PWL_ASSERT_IMP(a_hit_means_ok, clk, rst_n, rsp_valid && rsp_data.exact_hit, rsp_data.status == ST_OK, "exact hit with error status")

    // A stalled result stays put.
    `PWL_ASSERT_NXT(a_rsp_holds, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind piecewise_linear_runtime_table_unit pwlrt_checker u_pwlrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: test/pwlrt_result_checker.sv
// ----------------------------------------------------------------------------
// pwlrt_result_checker
// Watches both channels of the runtime table unit, keeps its own copy of the
// breakpoint tables, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module pwlrt_result_checker
    import pwlrt_pkg::*;
#(
    parameter int MACHINES = 8,
    parameter int POINTS   = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    input  wire logic   req_stall,
    input  wire req_t   req_data,
    input  wire logic   rsp_valid,
    input  wire logic   rsp_stall,
    input  wire rsp_t   rsp_data,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked,
    output int unsigned exact_hits,
    output int unsigned interpolations,
    output int unsigned error_statuses
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow breakpoint tables, sorted by ascending key per machine.
    logic [KEY_W-1:0] shadow_key [MACHINES][POINTS];
    logic [RT_W-1:0]  shadow_rt  [MACHINES][POINTS];
    int unsigned      shadow_count [MACHINES];

    rsp_t awaited_results [$];
    rsp_t want;

    // First slot whose key is at or above the given key, or the count if none.
    function automatic int unsigned first_slot_at_or_above(int unsigned m,
                                                           logic [KEY_W-1:0] key);
        int unsigned i;
        for (i = 0; i < shadow_count[m]; i++)
        begin
            if (shadow_key[m][i] >= key)
                break;
        end
        return i;
    endfunction

    // Applies one command to the shadow tables and returns the result it gives.
    function automatic rsp_t runtime_table_result(req_t item);
        rsp_t             res;
        int unsigned      m;
        int unsigned      cnt;
        int unsigned      pos;
        int unsigned      j;
        logic             hit;
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] k1;
        logic [RT_W-1:0]  r0;
        logic [RT_W-1:0]  r1;
        logic [63:0]      span;
        logic [63:0]      offset;
        logic [63:0]      num;
        logic [63:0]      quot;
        logic [63:0]      rmd;
        logic [63:0]      base_rt;
        logic [63:0]      scaled;
        logic [FRAC_W-1:0] done;

        res     = '0;
        res.status = ST_OK;
        hit     = 1'b0;
        base_rt = '0;
        m       = item.machine;
        if (m >= MACHINES)
        begin
            res.status = ST_NO_TABLE;
        end
        else if (item.cmd == CMD_LOAD)
        begin
            cnt = shadow_count[m];
            pos = first_slot_at_or_above(m, item.units);
            if (pos < cnt && shadow_key[m][pos] == item.units)
            begin
                shadow_rt[m][pos] = item.new_runtime;
            end
            else if (cnt >= POINTS)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                for (j = cnt; j > pos; j--)
                begin
                    shadow_key[m][j] = shadow_key[m][j-1];
                    shadow_rt[m][j]  = shadow_rt[m][j-1];
                end
                shadow_key[m][pos] = item.units;
                shadow_rt[m][pos]  = item.new_runtime;
                shadow_count[m]    = cnt + 1;
            end
        end
        else
        begin
            cnt = shadow_count[m];
            if (cnt == 0)
            begin
                res.status = ST_NO_TABLE;
            end
            else
            begin
                pos = first_slot_at_or_above(m, item.units);
                if (pos < cnt && shadow_key[m][pos] == item.units)
                begin
                    base_rt = {32'd0, shadow_rt[m][pos]};
                    hit     = 1'b1;
                end
                else if (pos == 0 || pos >= cnt)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    k0     = shadow_key[m][pos-1];
                    r0     = shadow_rt[m][pos-1];
                    k1     = shadow_key[m][pos];
                    r1     = shadow_rt[m][pos];
                    span   = {32'd0, k1 - k0};
                    offset = {32'd0, item.units - k0};
                    num    = {32'd0, r0} * (span - offset) + {32'd0, r1} * offset;
                    quot   = num / span;
                    rmd    = num % span;
                    // Round to nearest, halves up.
                    if (rmd * 2 >= span)
                        quot = quot + 1;
                    base_rt = quot;
                end
            end
        end

        if (res.status == ST_OK && item.cmd == CMD_QUERY)
        begin
            done = (item.completed > ONE_Q16) ? ONE_Q16 : item.completed;
            scaled = (base_rt * (ONE_Q16 - done) + 64'd32768) >> 16;
            res.runtime_left = scaled[RT_W-1:0];
            res.exact_hit    = hit;
            if (hit)
                exact_hits++;
            else
                interpolations++;
        end
        if (res.status != ST_OK)
            error_statuses++;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MACHINES; i++)
                shadow_count[i] = 0;
            awaited_results.delete();
            fail_count     = 0;
            pending        = 0;
            checked        = 0;
            exact_hits     = 0;
            interpolations = 0;
            error_statuses = 0;
        end
        else
        begin
            // A result always belongs to an older command than one taken at
            // the same edge, so results are checked before new predictions.
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_data.runtime_left !== want.runtime_left)
                    begin
                        $error("result %0d runtime_left: expected %0h, got %0h",
                               checked, want.runtime_left, rsp_data.runtime_left);
                        fail_count++;
                    end
                    if (rsp_data.exact_hit !== want.exact_hit)
                    begin
                        $error("result %0d exact_hit: expected %0b, got %0b",
                               checked, want.exact_hit, rsp_data.exact_hit);
                        fail_count++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("result %0d status: expected %0d, got %0d",
                               checked, want.status, rsp_data.status);
                        fail_count++;
                    end
                    checked++;
                end
            end
            if (req_valid && !req_stall)
                awaited_results.push_back(runtime_table_result(req_data));
            pending = awaited_results.size();
        end
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the piecewise-linear runtime table unit: directed loads and
// queries, then shaped random traffic under three idle patterns and one long
// output hold, with every result checked by pwlrt_result_checker.
// ----------------------------------------------------------------------------
module testbench
    import pwlrt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MACHINES = 8;
    localparam int POINTS   = 16;

    // Random items per idle phase; three phases give about 400 in total.
    localparam int PHASE_ITEMS = 130;
    // Recently loaded keys remembered per machine to aim queries at.
    localparam int POOL_DEPTH  = 32;
    // Length of the long output hold that backs the block up.
    localparam int HOLD_CYCLES = 400;
    // Quiet cycles after the last result, well past the slowest command.
    localparam int DRAIN_CYCLES = 150;
    // Cycles with no transfer on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned exact_hits;
    int unsigned interpolations;
    int unsigned error_statuses;

    // Idle percentages for each side, changed between phases.
    int send_idle_pct;
    int rsp_idle_pct;

    // The stimulus asks for a long hold by raising hold_requests; the receiver
    // process serves each request once and counts the hold down itself.
    int hold_requests;
    int holds_served;
    int hold_left;

    int loads_sent;
    int queries_sent;
    int idle_cycles;

    logic [KEY_W-1:0] key_pool [MACHINES][POOL_DEPTH];
    int               pool_n   [MACHINES];

    piecewise_linear_runtime_table_unit
    #(
        .MACHINES (MACHINES),
        .POINTS   (POINTS)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    pwlrt_result_checker
    #(
        .MACHINES (MACHINES),
        .POINTS   (POINTS)
    )
    result_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .exact_hits     (exact_hits),
        .interpolations (interpolations),
        .error_statuses (error_statuses)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic req_t make_req(logic cmd, int m, logic [KEY_W-1:0] units,
                                      logic [RT_W-1:0] rt, logic [FRAC_W-1:0] done);
        req_t item;
        item.cmd         = cmd;
        item.machine     = MACHINE_W'(m);
        item.units       = units;
        item.new_runtime = rt;
        item.completed   = done;
        return item;
    endfunction

    // Presents one command at a falling edge after a random gap and holds it
    // until the block takes it. The valid line stays high straight into the
    // next command when no gap is drawn, so it never drops and rises in one step.
    task automatic offer_command(input req_t item);
        int m;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_data  <= item;
        req_valid <= 1'b1;
        m = item.machine;
        if (item.cmd == CMD_LOAD)
        begin
            loads_sent++;
            // Remember the key so that later queries can land on or near it.
            if (pool_n[m] < POOL_DEPTH)
            begin
                key_pool[m][pool_n[m]] = item.units;
                pool_n[m]++;
            end
            else
            begin
                key_pool[m][$urandom_range(POOL_DEPTH-1)] = item.units;
            end
        end
        else
        begin
            queries_sent++;
        end
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
    endtask

    // One random command. Loads mix overwrites of known keys, keys packed
    // closely around known ones (short spans stress the rounding), the key
    // extremes and free keys. Queries mostly hit a known key or fall between
    // two known keys, so most of them reach the exact and interpolating
    // paths; the rest probe the range limits and empty tables.
    function automatic req_t random_command();
        req_t             item;
        int               m;
        int unsigned      pick;
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;

        m = $urandom_range(MACHINES-1);
        item.machine     = MACHINE_W'(m);
        item.cmd         = ($urandom_range(99) < 45) ? CMD_LOAD : CMD_QUERY;
        item.new_runtime = $urandom;
        item.completed   = FRAC_W'($urandom);
        pick = $urandom_range(19);

        if (item.cmd == CMD_LOAD)
        begin
            if (pool_n[m] > 0 && pick < 4)
                item.units = key_pool[m][$urandom_range(pool_n[m]-1)];
            else if (pool_n[m] > 0 && pick < 10)
                item.units = key_pool[m][$urandom_range(pool_n[m]-1)]
                             + $urandom_range(16) - 8;
            else if (pick < 12)
                item.units = ($urandom_range(1) != 0) ? '1 : '0;
            else
                item.units = $urandom;

            case ($urandom_range(3))
                0: item.new_runtime = $urandom_range(65535);
                1: item.new_runtime = ($urandom_range(1) != 0) ? '1 : '0;
                default: item.new_runtime = $urandom;
            endcase
        end
        else
        begin
            if (pool_n[m] == 0 || pick < 3)
            begin
                item.units = $urandom;
            end
            else if (pick < 10)
            begin
                item.units = key_pool[m][$urandom_range(pool_n[m]-1)];
            end
            else if (pick < 12)
            begin
                item.units = key_pool[m][$urandom_range(pool_n[m]-1)]
                             + (($urandom_range(1) != 0) ? 32'd1 : 32'hFFFF_FFFF);
            end
            else
            begin
                a  = key_pool[m][$urandom_range(pool_n[m]-1)];
                b  = key_pool[m][$urandom_range(pool_n[m]-1)];
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                item.units = lo + $urandom_range(hi - lo);
            end

            case ($urandom_range(6))
                0: item.completed = '0;
                1: item.completed = ONE_Q16;
                2: item.completed = FRAC_W'($urandom_range(131071, 65537));
                3: item.completed = FRAC_W'($urandom);
                default: item.completed = FRAC_W'($urandom_range(65536));
            endcase
        end
        return item;
    endfunction

    // Receiver: stalls at random by rsp_idle_pct, except while a long hold
    // is being served, which it counts down one falling edge at a time.
    initial
    begin
        rsp_stall    = 1'b0;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
            end
        end
    end

    // Watchdog: a run that goes this long without any transfer is hung,
    // and a leftover expectation ends up here too.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("piecewise_linear_runtime_table_unit regression: fail");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_data      = '0;
        send_idle_pct = 17;
        rsp_idle_pct  = 81;
        hold_requests = 0;
        loads_sent    = 0;
        queries_sent  = 0;
        for (int i = 0; i < MACHINES; i++)
            pool_n[i] = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Query on a machine that has never been loaded.
        offer_command(make_req(CMD_QUERY, 3, 32'd1000, '0, '0));

        // Machine 0 spans the whole key range, with the largest runtime at the
        // top; queries cover both exact ends, the midpoint, completion of
        // nothing, of everything, and a completed value above one.
        offer_command(make_req(CMD_LOAD, 0, 32'h0000_0000, 32'h0000_0000, '0));
        offer_command(make_req(CMD_LOAD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
        offer_command(make_req(CMD_QUERY, 0, 32'h8000_0000, '0, '0));
        offer_command(make_req(CMD_QUERY, 0, 32'h7FFF_FFFF, '0, ONE_Q16));
        offer_command(make_req(CMD_QUERY, 0, 32'h0000_0001, '0, 17'h1FFFF));
        offer_command(make_req(CMD_QUERY, 0, 32'hFFFF_FFFF, '0, '0));
        offer_command(make_req(CMD_QUERY, 0, 32'h0000_0000, '0, 17'd1));

        // A single breakpoint: one below and one above are out of range.
        offer_command(make_req(CMD_LOAD, 1, 32'd500, 32'h0001_2345, '0));
        offer_command(make_req(CMD_QUERY, 1, 32'd499, '0, '0));
        offer_command(make_req(CMD_QUERY, 1, 32'd501, '0, '0));
        offer_command(make_req(CMD_QUERY, 1, 32'd500, '0, 17'd32768));

        // Fill machine 7 in descending key order so each insert shifts the
        // whole table, then try a new key on the full table, overwrite an
        // existing one and interpolate across the overwritten point.
        for (int i = 0; i < POINTS; i++)
            offer_command(make_req(CMD_LOAD, 7, 32'(1600 - 100 * i),
                                   32'(1000 * (i + 1)), '0));
        offer_command(make_req(CMD_LOAD, 7, 32'd50, 32'd7, '0));
        offer_command(make_req(CMD_LOAD, 7, 32'd800, 32'hABCD_EF01, '0));
        offer_command(make_req(CMD_QUERY, 7, 32'd850, '0, 17'd65535));

        // Random traffic in three idle patterns: a slow receiver, a slow
        // sender, then neither. The last phase opens with a long output hold
        // while commands keep coming, so the block fills up and stalls.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 17;
                    rsp_idle_pct  = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    rsp_idle_pct  = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_idle_pct  = 0;
                    hold_requests++;
                end
            endcase
            repeat (PHASE_ITEMS) offer_command(random_command());
        end

        @(negedge clk);
        req_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d loads and %0d queries over %0d machines, with three idle patterns",
                 loads_sent, queries_sent, MACHINES);
        $display("and one long output hold; %0d results checked: %0d exact, %0d interpolated, %0d errors.",
                 checked, exact_hits, interpolations, error_statuses);
        if (fail_count == 0)
            $display("piecewise_linear_runtime_table_unit regression: pass");
        else
            $display("piecewise_linear_runtime_table_unit regression: fail");
        $finish;
    end

endmodule
